>>> design/wth_pkg.sv
// Shared types, constants and codes for the weighted time histogram.
package wth_pkg;

  // Storage and number format
  localparam int MAX_BINS  = 1024;
  localparam int BIN_AW    = $clog2(MAX_BINS);
  localparam int USED_W    = BIN_AW + 1;
  localparam int FRAC_BITS = 24;
  localparam int SUM_W     = 48;
  localparam int IDX_W     = 10;
  localparam int CFG_W     = 40;
  localparam int CFG_AW    = 3;

  // Iteration lengths of the sequential units
  localparam int TD_W   = 35;  // magnitude of 2*(t-origin)+w
  localparam int SQ_IT  = 32;  // root bits
  localparam int PD_W   = 48;  // quotient bits of pz
  localparam int CNT_W  = 6;

  // Request commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_BIN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_BIN_ORIGIN   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_BIN_WIDTH    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_BIN_COUNT    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_X_OFFSET     = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_Y_OFFSET     = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_X_POWER      = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_Y_POWER      = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_REF_MOMENTUM = 3'd7;

  // Multiply sequence steps
  localparam logic [3:0] MS_SQX  = 4'd0;
  localparam logic [3:0] MS_SQY  = 4'd1;
  localparam logic [3:0] MS_CXL  = 4'd2;
  localparam logic [3:0] MS_CXH  = 4'd3;
  localparam logic [3:0] MS_CYL  = 4'd4;
  localparam logic [3:0] MS_CYH  = 4'd5;
  localparam logic [3:0] MS_SXP  = 4'd6;
  localparam logic [3:0] MS_SYP  = 4'd7;
  localparam logic [3:0] MS_PL   = 4'd8;
  localparam logic [3:0] MS_PH   = 4'd9;
  localparam logic [3:0] MS_COMB = 4'd10;
  localparam logic [3:0] MS_WGT  = 4'd11;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] arrival_time;
    logic signed [31:0] x_pos;
    logic signed [31:0] x_slope;
    logic signed [31:0] y_pos;
    logic signed [31:0] y_slope;
    logic signed [31:0] momentum_dev;
    logic [9:0]         bin_select;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   bin_index;
    logic               was_binned;
    logic [47:0]        long_momentum;
    logic signed [47:0] x_bin_sum;
    logic signed [47:0] y_bin_sum;
    logic [31:0]        binned_total;
  } out_t;

  typedef struct packed {
    logic signed [31:0] bin_origin;
    logic [30:0]        bin_width;
    logic [10:0]        bin_count;
    logic signed [31:0] x_offset;
    logic signed [31:0] y_offset;
    logic [1:0]         x_weight_power;
    logic [1:0]         y_weight_power;
    logic [39:0]        ref_momentum;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    bin_origin:     32'sd0,
    bin_width:      31'd1,
    bin_count:      11'd1024,
    x_offset:       32'sd0,
    y_offset:       32'sd0,
    x_weight_power: 2'd1,
    y_weight_power: 2'd1,
    ref_momentum:   40'd65536
  };

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       cnt_clr;
    logic       clr_en;
    logic       prep;
    logic       mag;
    logic       mul_en;
    logic [3:0] mul_step;
    logic       sqrt_start;
    logic       pdiv_start;
    logic       upd;
    logic       push;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tdv_busy;
    logic sq_busy;
    logic pd_busy;
    logic in_range;
    logic clr_last;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> design/wth_ram.sv
// Generic single write port RAM with registered read.
module wth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/wth_ctrl.sv
// Sequencing state machine of the weighted time histogram.
module wth_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  output logic               in_ready,
  output wth_pkg::ctl_cmd_t  cmd,
  input  wth_pkg::ctl_sts_t  sts
);

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_PREP  = 13'b0000000000100,
    S_MAG   = 13'b0000000001000,
    S_MUL   = 13'b0000000010000,
    S_SQS   = 13'b0000000100000,
    S_SQ    = 13'b0000001000000,
    S_PDS   = 13'b0000010000000,
    S_PD    = 13'b0000100000000,
    S_BWAIT = 13'b0001000000000,
    S_RD    = 13'b0010000000000,
    S_RDW   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic       from_cmd_r, from_cmd_nxt;
  logic [3:0] step_r, step_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    from_cmd_nxt = from_cmd_r;
    step_nxt     = step_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = from_cmd_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          from_cmd_nxt = (in_cmd == wth_pkg::CMD_CLEAR);
          case (in_cmd)
            wth_pkg::CMD_CLEAR: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_CLR;
            end
            wth_pkg::CMD_BIN:  state_nxt = S_PREP;
            wth_pkg::CMD_READ: state_nxt = S_RD;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        step_nxt  = wth_pkg::MS_SQX;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = step_r;
        if (step_r == wth_pkg::MS_WGT) begin
          state_nxt = S_SQS;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_SQS: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQ;
      end
      S_SQ: begin
        if (!sts.sq_busy) begin
          state_nxt = S_PDS;
        end
      end
      S_PDS: begin
        cmd.pdiv_start = 1'b1;
        state_nxt      = S_PD;
      end
      S_PD: begin
        if (!sts.pd_busy) begin
          state_nxt = S_BWAIT;
        end
      end
      S_BWAIT: begin
        if (!sts.tdv_busy) begin
          state_nxt = sts.in_range ? S_RD : S_DONE;
        end
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      from_cmd_r <= 1'b0;
      step_r     <= wth_pkg::MS_SQX;
    end else begin
      state_r    <= state_nxt;
      from_cmd_r <= from_cmd_nxt;
      step_r     <= step_nxt;
    end
  end

endmodule

>>> design/wth_dp.sv
// Datapath: configuration, arithmetic units, histogram memory and result register.
module wth_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wth_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [wth_pkg::CFG_W-1:0]     cfg_data,
  input  wth_pkg::in_t                  in_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output wth_pkg::out_t                 out_data,
  input  wth_pkg::ctl_cmd_t             cmd,
  output wth_pkg::ctl_sts_t             sts
);

  localparam int SW  = wth_pkg::SUM_W;
  localparam int FB  = wth_pkg::FRAC_BITS;
  localparam int AW  = wth_pkg::BIN_AW;
  localparam int TDW = wth_pkg::TD_W;
  localparam int PDW = wth_pkg::PD_W;
  localparam int CW  = wth_pkg::CNT_W;
  localparam logic [95:0] WGT_LIM  = (96'd1 << (SW - 1)) - 96'd1;
  localparam logic [63:0] NSQ_BASE = 64'd1 << (2 * FB);

  // Weight of one plane: power 0 counts, 1 is d, 2 is d^2, 3 is signed |d|^3
  function automatic logic [SW-1:0] calc_weight(input logic [1:0] pw, input logic neg,
                                                input logic [31:0] m, input logic [63:0] sq,
                                                input logic [95:0] cube);
    logic [95:0] mag;
    logic        sgn;
    mag = '0;
    sgn = 1'b0;
    case (pw)
      2'd0: mag = 96'd1 << FB;
      2'd1: begin
        mag = 96'(m);
        sgn = neg;
      end
      2'd2: mag = 96'(sq >> FB);
      default: begin
        mag = cube >> (2 * FB);
        sgn = neg;
      end
    endcase
    if (mag > WGT_LIM) begin
      mag = WGT_LIM;
    end
    return sgn ? SW'(-mag) : SW'(mag);
  endfunction

  wth_pkg::cfg_t cfg_r;
  wth_pkg::in_t  item_r;
  wth_pkg::out_t out_r, res;
  logic          out_valid_r;

  logic [32:0] dx_r, dy_r, a_r;
  logic [34:0] n_r;
  logic [31:0] mx_r, my_r, ux_r, uy_r, aa_r;
  logic        negx_r, negy_r, a_ok_r, nneg_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] sqx_r, sqy_r, cxl_r, cxh_r, cyl_r, cyh_r, sxp_r, syp_r, pl_r, nsq_r;
  logic [39:0] ph_r;
  logic [95:0] cubex_r, cubey_r;
  logic [71:0] num_r;
  logic [SW-1:0] wx_r, wy_r;

  logic [TDW-1:0] tdv_num_r, tdv_q_r;
  logic [31:0]    tdv_rem_r, tdv_den_r;
  logic [CW-1:0]  tdv_cnt_r;
  logic           tdv_busy_r;
  logic [32:0]    tdv_sh;
  logic [33:0]    tdv_dif;

  logic [63:0]   sq_n_r;
  logic [32:0]   sq_rem_r;
  logic [31:0]   sq_root_r;
  logic [CW-1:0] sq_cnt_r;
  logic          sq_busy_r;
  logic [34:0]   sq_sh, sq_trial;

  logic [PDW-1:0] pd_num_r, pd_q_r;
  logic [31:0]    pd_rem_r;
  logic [CW-1:0]  pd_cnt_r;
  logic           pd_busy_r;
  logic [32:0]    pd_sh;
  logic [33:0]    pd_dif;

  logic [31:0]    bins_r;
  logic [AW-1:0]  clr_addr_r;
  logic [2*SW-1:0] sums_r, ram_rdata, ram_wdata;
  logic [AW-1:0]  ram_waddr, ram_raddr, qidx, sel_idx;
  logic           ram_we;

  logic [30:0]       w_eff;
  logic [32:0]       tdiff;
  logic [wth_pkg::USED_W-1:0] used;
  logic              in_range, sel_ok, is_bin, is_read;
  logic [SW-1:0]     sumx, sumy;

  assign is_bin  = (item_r.cmd == wth_pkg::CMD_BIN);
  assign is_read = (item_r.cmd == wth_pkg::CMD_READ);
  assign w_eff   = (cfg_r.bin_width == '0) ? 31'd1 : cfg_r.bin_width;
  assign tdiff   = {item_r.arrival_time[31], item_r.arrival_time}
                 - {cfg_r.bin_origin[31], cfg_r.bin_origin};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= wth_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wth_pkg::CFG_BIN_ORIGIN:   cfg_r.bin_origin     <= cfg_data[31:0];
        wth_pkg::CFG_BIN_WIDTH:    cfg_r.bin_width      <= cfg_data[30:0];
        wth_pkg::CFG_BIN_COUNT:    cfg_r.bin_count      <= cfg_data[10:0];
        wth_pkg::CFG_X_OFFSET:     cfg_r.x_offset       <= cfg_data[31:0];
        wth_pkg::CFG_Y_OFFSET:     cfg_r.y_offset       <= cfg_data[31:0];
        wth_pkg::CFG_X_POWER:      cfg_r.x_weight_power <= cfg_data[1:0];
        wth_pkg::CFG_Y_POWER:      cfg_r.y_weight_power <= cfg_data[1:0];
        wth_pkg::CFG_REF_MOMENTUM: cfg_r.ref_momentum   <= cfg_data[39:0];
      endcase
    end
  end

  // Capture request, then differences, then magnitudes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.prep) begin
      dx_r <= {item_r.x_pos[31], item_r.x_pos} - {cfg_r.x_offset[31], cfg_r.x_offset};
      dy_r <= {item_r.y_pos[31], item_r.y_pos} - {cfg_r.y_offset[31], cfg_r.y_offset};
      n_r  <= {tdiff[32], tdiff, 1'b0} + {4'b0, w_eff};
      a_r  <= (33'd1 << FB) + {item_r.momentum_dev[31], item_r.momentum_dev};
    end
    if (cmd.mag) begin
      mx_r   <= dx_r[32] ? 32'(-dx_r) : dx_r[31:0];
      my_r   <= dy_r[32] ? 32'(-dy_r) : dy_r[31:0];
      negx_r <= dx_r[32];
      negy_r <= dy_r[32];
      ux_r   <= item_r.x_slope[31] ? -item_r.x_slope : item_r.x_slope;
      uy_r   <= item_r.y_slope[31] ? -item_r.y_slope : item_r.y_slope;
      a_ok_r <= !a_r[32] && (a_r != '0);
      aa_r   <= a_r[31:0];
      nneg_r <= n_r[34];
    end
  end

  // Shared 32x32 multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_step)
      wth_pkg::MS_SQX: begin mul_a = mx_r;         mul_b = mx_r; end
      wth_pkg::MS_SQY: begin mul_a = my_r;         mul_b = my_r; end
      wth_pkg::MS_CXL: begin mul_a = sqx_r[31:0];  mul_b = mx_r; end
      wth_pkg::MS_CXH: begin mul_a = sqx_r[63:32]; mul_b = mx_r; end
      wth_pkg::MS_CYL: begin mul_a = sqy_r[31:0];  mul_b = my_r; end
      wth_pkg::MS_CYH: begin mul_a = sqy_r[63:32]; mul_b = my_r; end
      wth_pkg::MS_SXP: begin mul_a = ux_r;         mul_b = ux_r; end
      wth_pkg::MS_SYP: begin mul_a = uy_r;         mul_b = uy_r; end
      wth_pkg::MS_PL:  begin mul_a = cfg_r.ref_momentum[31:0]; mul_b = aa_r; end
      wth_pkg::MS_PH:  begin mul_a = {24'b0, cfg_r.ref_momentum[39:32]}; mul_b = aa_r; end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Store products, combine partial products, form weights
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        wth_pkg::MS_SQX: sqx_r <= mul_p;
        wth_pkg::MS_SQY: sqy_r <= mul_p;
        wth_pkg::MS_CXL: cxl_r <= mul_p;
        wth_pkg::MS_CXH: cxh_r <= mul_p;
        wth_pkg::MS_CYL: cyl_r <= mul_p;
        wth_pkg::MS_CYH: cyh_r <= mul_p;
        wth_pkg::MS_SXP: sxp_r <= mul_p;
        wth_pkg::MS_SYP: syp_r <= mul_p;
        wth_pkg::MS_PL:  pl_r  <= mul_p;
        wth_pkg::MS_PH:  ph_r  <= mul_p[39:0];
        wth_pkg::MS_COMB: begin
          cubex_r <= {cxh_r, 32'b0} + {32'b0, cxl_r};
          cubey_r <= {cyh_r, 32'b0} + {32'b0, cyl_r};
          nsq_r   <= NSQ_BASE + sxp_r + syp_r;
          num_r   <= {ph_r, 32'b0} + {8'b0, pl_r};
        end
        wth_pkg::MS_WGT: begin
          wx_r <= calc_weight(cfg_r.x_weight_power, negx_r, mx_r, sqx_r, cubex_r);
          wy_r <= calc_weight(cfg_r.y_weight_power, negy_r, my_r, sqy_r, cubey_r);
        end
        default: ;
      endcase
    end
  end

  // Bin divider: |2(t-origin)+w| / 2w, one quotient bit per cycle
  assign tdv_sh  = {tdv_rem_r, tdv_num_r[TDW-1]};
  assign tdv_dif = {1'b0, tdv_sh} - {2'b0, tdv_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdv_busy_r <= 1'b0;
    end else if (cmd.mag) begin
      tdv_busy_r <= 1'b1;
    end else if (tdv_busy_r && tdv_cnt_r == CW'(1)) begin
      tdv_busy_r <= 1'b0;
    end
    if (cmd.mag) begin
      tdv_num_r <= n_r[34] ? -n_r : n_r;
      tdv_den_r <= {w_eff, 1'b0};
      tdv_rem_r <= '0;
      tdv_q_r   <= '0;
      tdv_cnt_r <= CW'(TDW);
    end else if (tdv_busy_r) begin
      tdv_num_r <= tdv_num_r << 1;
      tdv_rem_r <= tdv_dif[33] ? tdv_sh[31:0] : tdv_dif[31:0];
      tdv_q_r   <= {tdv_q_r[TDW-2:0], !tdv_dif[33]};
      tdv_cnt_r <= tdv_cnt_r - CW'(1);
    end
  end

  // Square root of 1 + xp^2 + yp^2, two radicand bits per cycle
  assign sq_sh    = {sq_rem_r, sq_n_r[63:62]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r && sq_cnt_r == CW'(1)) begin
      sq_busy_r <= 1'b0;
    end
    if (cmd.sqrt_start) begin
      sq_n_r    <= nsq_r;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= CW'(wth_pkg::SQ_IT);
    end else if (sq_busy_r) begin
      sq_n_r <= sq_n_r << 2;
      if (sq_sh >= sq_trial) begin
        sq_rem_r  <= 33'(sq_sh - sq_trial);
        sq_root_r <= {sq_root_r[30:0], 1'b1};
      end else begin
        sq_rem_r  <= 33'(sq_sh);
        sq_root_r <= {sq_root_r[30:0], 1'b0};
      end
      sq_cnt_r <= sq_cnt_r - CW'(1);
    end
  end

  // pz divider: P0*A / root, top quotient bits are known zero
  assign pd_sh  = {pd_rem_r, pd_num_r[PDW-1]};
  assign pd_dif = {1'b0, pd_sh} - {2'b0, sq_root_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_busy_r <= 1'b0;
    end else if (cmd.pdiv_start) begin
      pd_busy_r <= 1'b1;
    end else if (pd_busy_r && pd_cnt_r == CW'(1)) begin
      pd_busy_r <= 1'b0;
    end
    if (cmd.pdiv_start) begin
      pd_rem_r <= {8'b0, num_r[71:PDW]};
      pd_num_r <= num_r[PDW-1:0];
      pd_q_r   <= '0;
      pd_cnt_r <= CW'(PDW);
    end else if (pd_busy_r) begin
      pd_num_r <= pd_num_r << 1;
      pd_rem_r <= pd_dif[33] ? pd_sh[31:0] : pd_dif[31:0];
      pd_q_r   <= {pd_q_r[PDW-2:0], !pd_dif[33]};
      pd_cnt_r <= pd_cnt_r - CW'(1);
    end
  end

  // Range check against the bins in use
  assign used = ({21'b0, cfg_r.bin_count} > 32'(wth_pkg::MAX_BINS))
              ? wth_pkg::USED_W'(wth_pkg::MAX_BINS)
              : wth_pkg::USED_W'(cfg_r.bin_count);
  assign in_range = nneg_r ? ((tdv_q_r == '0) && (used != '0))
                           : (tdv_q_r < TDW'(used));
  assign qidx     = tdv_q_r[AW-1:0];
  assign sel_idx  = AW'(item_r.bin_select);
  assign sel_ok   = 32'(item_r.bin_select) < 32'(wth_pkg::MAX_BINS);

  // Histogram memory: x sum high, y sum low
  assign sumx      = ram_rdata[2*SW-1:SW] + wx_r;
  assign sumy      = ram_rdata[SW-1:0] + wy_r;
  assign ram_we    = cmd.clr_en || (cmd.upd && is_bin);
  assign ram_waddr = cmd.clr_en ? clr_addr_r : qidx;
  assign ram_wdata = cmd.clr_en ? '0 : {sumx, sumy};
  assign ram_raddr = is_read ? sel_idx : qidx;

  wth_ram #(
    .WIDTH (2 * SW),
    .DEPTH (wth_pkg::MAX_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clear sweep address, binned counter and captured sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      bins_r     <= '0;
    end else begin
      if (cmd.clr_en) begin
        clr_addr_r <= (clr_addr_r == AW'(wth_pkg::MAX_BINS - 1)) ? '0 : clr_addr_r + AW'(1);
      end
      if (cmd.cnt_clr) begin
        bins_r <= '0;
      end else if (cmd.upd && is_bin) begin
        bins_r <= bins_r + 32'd1;
      end
    end
    if (cmd.upd) begin
      if (is_bin) begin
        sums_r <= {sumx, sumy};
      end else begin
        sums_r <= sel_ok ? ram_rdata : '0;
      end
    end
  end

  // Assemble result
  always_comb begin
    res = '0;
    case (item_r.cmd)
      wth_pkg::CMD_CLEAR: ;
      wth_pkg::CMD_BIN: begin
        res.binned_total = bins_r;
        if (in_range) begin
          res.bin_index     = wth_pkg::IDX_W'(qidx);
          res.was_binned    = 1'b1;
          res.long_momentum = a_ok_r ? pd_q_r : '0;
          res.x_bin_sum     = sums_r[2*SW-1:SW];
          res.y_bin_sum     = sums_r[SW-1:0];
        end
      end
      wth_pkg::CMD_READ: begin
        res.bin_index    = item_r.bin_select;
        res.x_bin_sum    = sums_r[2*SW-1:SW];
        res.y_bin_sum    = sums_r[SW-1:0];
        res.binned_total = bins_r;
      end
      default: res.binned_total = bins_r;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.push) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.tdv_busy = tdv_busy_r;
  assign sts.sq_busy  = sq_busy_r;
  assign sts.pd_busy  = pd_busy_r;
  assign sts.in_range = in_range;
  assign sts.clr_last = (clr_addr_r == AW'(wth_pkg::MAX_BINS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

>>> design/weighted_time_histogram.sv
// Weighted time histogram: top level joining controller and datapath.
//
// Input channel in_valid/in_ready/in_data carries one request: clear both
// histograms, bin one particle, or read one bin. Every request gives exactly
// one result on out_valid/out_ready/out_data. One request is worked at a time.
// For a binned particle the 32-step square root and the 48-step pz quotient
// loop run one after the other, while the 35-step bin divider runs beside
// them; a particle outside the bins skips the RAM read and update. A read
// fetches its bin and then gives its result; an unused command gives it at once.
// A clear request sweeps the histogram RAM one bin per cycle over all MAX_BINS
// (1024) bins. in_ready rises the cycle after a result is pushed, so a new
// particle is taken only once the last result has been pushed.
// After reset the block runs the same sweep before in_ready rises;
// configuration writes are taken during it. Configuration goes through
// cfg_we/cfg_addr/cfg_data with no wait; the user must write it only while
// idle, and the block itself does not enforce this. A finished result sits
// in the output register; while the receiver stalls the next request is
// still accepted and worked, and only its own result waits for it to free.
module weighted_time_histogram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  wth_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output wth_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [wth_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [wth_pkg::CFG_W-1:0]  cfg_data
);

  wth_pkg::ctl_cmd_t ctl_cmd;
  wth_pkg::ctl_sts_t ctl_sts;

  wth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .cmd      (ctl_cmd),
    .sts      (ctl_sts)
  );

  wth_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (ctl_cmd),
    .sts       (ctl_sts)
  );

`ifndef SYNTHESIS
  // Sweep writes never overlap request acceptance
  a_clr_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.clr_en |-> !in_ready) else $error("clear sweep while ready");

  // Result is pushed only into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.push |-> ctl_sts.out_free) else $error("push into full output");

  // One request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second request taken");

  // A binned particle always counts itself
  a_binned_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.was_binned) |-> (out_data.binned_total != 32'd0))
    else $error("binned result with zero count");
`endif

endmodule

>>> tb/tb_weighted_time_histogram.sv
// Testbench for the weighted time histogram: random requests checked by a predictor.
`timescale 1ns / 1ps

module tb_weighted_time_histogram;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 150;
  localparam int PHASE_ITEMS    = 240;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [47:0] PZ_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [127:0] WGT_LIM  = (128'd1 << 47) - 1;

  // Histogram model: holds the bins, counter and settings, and checks results
  class histogram_scoreboard;
    wth_pkg::cfg_t cfg;
    logic [47:0]   x_bins [wth_pkg::MAX_BINS];
    logic [47:0]   y_bins [wth_pkg::MAX_BINS];
    logic [31:0]   particle_count;
    wth_pkg::out_t pending [$];
    int            mismatches;

    function void clear_bins();
      for (int i = 0; i < wth_pkg::MAX_BINS; i++) begin
        x_bins[i] = '0;
        y_bins[i] = '0;
      end
      particle_count = '0;
    endfunction

    function void init();
      cfg = wth_pkg::CFG_RESET;
      mismatches = 0;
      clear_bins();
    endfunction

    function void set_reg(logic [wth_pkg::CFG_AW-1:0] idx, logic [wth_pkg::CFG_W-1:0] val);
      case (idx)
        wth_pkg::CFG_BIN_ORIGIN:   cfg.bin_origin = val[31:0];
        wth_pkg::CFG_BIN_WIDTH:    cfg.bin_width = val[30:0];
        wth_pkg::CFG_BIN_COUNT:    cfg.bin_count = val[10:0];
        wth_pkg::CFG_X_OFFSET:     cfg.x_offset = val[31:0];
        wth_pkg::CFG_Y_OFFSET:     cfg.y_offset = val[31:0];
        wth_pkg::CFG_X_POWER:      cfg.x_weight_power = val[1:0];
        wth_pkg::CFG_Y_POWER:      cfg.y_weight_power = val[1:0];
        wth_pkg::CFG_REF_MOMENTUM: cfg.ref_momentum = val[39:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // (pos - offset)^power in Q.24, saturated, sign kept for odd powers
    function logic [47:0] plane_weight(longint pos, longint off, logic [1:0] power);
      longint       d;
      logic         neg;
      logic [127:0] m;
      logic [127:0] v;
      if (power == 2'd0) return 48'd1 << wth_pkg::FRAC_BITS;
      d = pos - off;
      m = (d < 0) ? 128'(-d) : 128'(d);
      neg = (d < 0) && (power != 2'd2);
      case (power)
        2'd1:    v = m;
        2'd2:    v = (m * m) >> wth_pkg::FRAC_BITS;
        default: v = (m * m * m) >> (2 * wth_pkg::FRAC_BITS);
      endcase
      if (v > WGT_LIM) v = WGT_LIM;
      return neg ? 48'(-v[47:0]) : v[47:0];
    endfunction

    // pz = P0 (1 + delta) / sqrt(1 + xp^2 + yp^2), floored, clamped to 48 bits
    function logic [47:0] pz(longint xp, longint yp, longint delta);
      longint       a;
      logic [63:0]  ux;
      logic [63:0]  uy;
      logic [63:0]  r;
      logic [127:0] q;
      a = (longint'(1) << wth_pkg::FRAC_BITS) + delta;
      if (a <= 0 || cfg.ref_momentum == 0) return '0;
      ux = (xp < 0) ? 64'(-xp) : 64'(xp);
      uy = (yp < 0) ? 64'(-yp) : 64'(yp);
      r = int_sqrt((64'd1 << (2 * wth_pkg::FRAC_BITS)) + ux * ux + uy * uy);
      if (r == 0) return '0;
      q = (128'(cfg.ref_momentum) * 128'(a)) / 128'(r);
      return (q > 128'(PZ_MAX)) ? PZ_MAX : q[47:0];
    endfunction

    // Note an accepted request: update the bins and queue its result
    function void note_request(wth_pkg::in_t req);
      wth_pkg::out_t res;
      longint        w;
      longint        ib;
      longint        used;
      res = '0;
      case (req.cmd)
        wth_pkg::CMD_CLEAR: clear_bins();
        wth_pkg::CMD_BIN: begin
          w = (cfg.bin_width == 0) ? 1 : longint'(cfg.bin_width);
          ib = (2 * (longint'(req.arrival_time) - longint'(cfg.bin_origin)) + w) / (2 * w);
          used = (cfg.bin_count > wth_pkg::MAX_BINS) ? wth_pkg::MAX_BINS
                                                     : longint'(cfg.bin_count);
          if (ib >= 0 && ib < used) begin
            x_bins[ib] = x_bins[ib] + plane_weight(req.x_pos, cfg.x_offset,
                                                   cfg.x_weight_power);
            y_bins[ib] = y_bins[ib] + plane_weight(req.y_pos, cfg.y_offset,
                                                   cfg.y_weight_power);
            particle_count = particle_count + 1;
            res.bin_index = ib[9:0];
            res.was_binned = 1'b1;
            res.long_momentum = pz(req.x_slope, req.y_slope, req.momentum_dev);
            res.x_bin_sum = x_bins[ib];
            res.y_bin_sum = y_bins[ib];
          end
          res.binned_total = particle_count;
        end
        wth_pkg::CMD_READ: begin
          res.bin_index = req.bin_select;
          res.x_bin_sum = x_bins[req.bin_select];
          res.y_bin_sum = y_bins[req.bin_select];
          res.binned_total = particle_count;
        end
        default: res.binned_total = particle_count;
      endcase
      pending.push_back(res);
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    endfunction

    // Check one result against the oldest expectation
    function void check_result(wth_pkg::out_t got);
      wth_pkg::out_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.binned_total, 0);
        return;
      end
      want = pending.pop_front();
      if (got.bin_index != want.bin_index)
        report("bin_index", got.bin_index, want.bin_index);
      if (got.was_binned != want.was_binned)
        report("was_binned", got.was_binned, want.was_binned);
      if (got.long_momentum != want.long_momentum)
        report("long_momentum", got.long_momentum, want.long_momentum);
      if (got.x_bin_sum != want.x_bin_sum)
        report("x_bin_sum", got.x_bin_sum, want.x_bin_sum);
      if (got.y_bin_sum != want.y_bin_sum)
        report("y_bin_sum", got.y_bin_sum, want.y_bin_sum);
      if (got.binned_total != want.binned_total)
        report("binned_total", got.binned_total, want.binned_total);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  wth_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  wth_pkg::out_t out_data;
  logic cfg_we;
  logic [wth_pkg::CFG_AW-1:0] cfg_addr;
  logic [wth_pkg::CFG_W-1:0]  cfg_data;

  histogram_scoreboard sb;
  bit   no_idle;
  int   stall_count = 0;

  weighted_time_histogram u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: end the run after too long with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(17);
  endfunction

  // Drive one request; returns at a falling edge after acceptance
  task send_request(wth_pkg::in_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task write_reg(logic [wth_pkg::CFG_AW-1:0] idx, logic [wth_pkg::CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Hold the sender until every result is back and the block is idle
  task drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_setting(logic [31:0] origin, logic [30:0] width, logic [10:0] count,
                     logic [31:0] xoff, logic [31:0] yoff, logic [1:0] xp,
                     logic [1:0] yp, logic [39:0] p0);
    write_reg(wth_pkg::CFG_BIN_ORIGIN, 40'(origin));
    write_reg(wth_pkg::CFG_BIN_WIDTH, 40'(width));
    write_reg(wth_pkg::CFG_BIN_COUNT, 40'(count));
    write_reg(wth_pkg::CFG_X_OFFSET, 40'(xoff));
    write_reg(wth_pkg::CFG_Y_OFFSET, 40'(yoff));
    write_reg(wth_pkg::CFG_X_POWER, 40'(xp));
    write_reg(wth_pkg::CFG_Y_POWER, 40'(yp));
    write_reg(wth_pkg::CFG_REF_MOMENTUM, p0);
  endtask

  function logic [31:0] rand_q824();
    if ($urandom_range(1)) return $urandom();
    return 32'($signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  // Random request, mostly particles aimed at or near the bins in use
  function wth_pkg::in_t make_request();
    wth_pkg::in_t req;
    int     pick;
    longint w;
    longint k;
    longint t;
    pick = $urandom_range(99);
    req.x_pos = rand_q824();
    req.y_pos = rand_q824();
    req.x_slope = rand_q824();
    req.y_slope = rand_q824();
    req.momentum_dev = rand_q824();
    req.bin_select = 10'($urandom());
    req.arrival_time = $urandom();
    if (pick < 2) begin
      req.cmd = wth_pkg::CMD_CLEAR;
    end else if (pick < 20) begin
      req.cmd = wth_pkg::CMD_READ;
      if ($urandom_range(3) != 0 && sb.cfg.bin_count != 0)
        req.bin_select = 10'($urandom_range(((sb.cfg.bin_count > wth_pkg::MAX_BINS)
                                             ? wth_pkg::MAX_BINS : sb.cfg.bin_count) - 1));
    end else if (pick < 25) begin
      req.cmd = CMD_UNUSED;
    end else begin
      req.cmd = wth_pkg::CMD_BIN;
      if (pick < 90) begin
        w = (sb.cfg.bin_width == 0) ? 1 : longint'(sb.cfg.bin_width);
        k = longint'($urandom_range(sb.cfg.bin_count + 3)) - 2;
        t = longint'(sb.cfg.bin_origin) + k * w
            + longint'($urandom_range(32'(w))) - w / 2;
        req.arrival_time = t[31:0];
      end
    end
    return req;
  endfunction

  // Receiver: stall at random and check every result
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = draw_gap();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  // Stimulus
  initial begin
    wth_pkg::in_t req;
    sb = new();
    sb.init();
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: bin edges, field extremes, every command, unused command
    req = '0;
    req.cmd = wth_pkg::CMD_READ; send_request(req);
    req.cmd = wth_pkg::CMD_BIN; req.arrival_time = 0; send_request(req);
    req.arrival_time = -1; req.x_pos = 32'h7FFF_FFFF; req.y_pos = 32'h8000_0000;
    send_request(req);
    req.arrival_time = -2; send_request(req);
    req.arrival_time = 1023; req.x_slope = 32'h8000_0000;
    req.y_slope = 32'h7FFF_FFFF; req.momentum_dev = 32'h7FFF_FFFF; send_request(req);
    req.arrival_time = 1024; send_request(req);
    req.arrival_time = 32'h8000_0000; send_request(req);
    req.arrival_time = 32'h7FFF_FFFF; send_request(req);
    req.arrival_time = 5; req.momentum_dev = -32'sh0100_0000; send_request(req);
    req.momentum_dev = -32'sh00FF_FFFF; req.x_slope = 0; req.y_slope = 0;
    send_request(req);
    req.momentum_dev = 32'h8000_0000; send_request(req);
    req.cmd = wth_pkg::CMD_READ; req.bin_select = 10'h3FF; send_request(req);
    req.bin_select = 0; send_request(req);
    req.cmd = CMD_UNUSED; send_request(req);
    req.cmd = wth_pkg::CMD_CLEAR; send_request(req);
    req.cmd = wth_pkg::CMD_READ; send_request(req);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: write_setting(1000, 3, 16, 0, 0, 0, 2, 40'd65536);
        1: write_setting(32'h8000_0000, 31'h7FFF_FFFF, 2, 32'h7FFF_FFFF,
                         32'h8000_0000, 3, 3, 40'hFF_FFFF_FFFF);
        2: write_setting(32'h7FFF_FFFF, 1, 1024, $urandom(), $urandom(), 2, 0, 40'd1);
        3: write_setting($urandom(), 0, 11'd2047, 32'h0100_0000, 32'hFF00_0000,
                         1, 3, {$urandom(), 8'($urandom())});
        4: write_setting(-5000, 100, 0, 0, 0, 1, 1, 40'd65536);
        5: write_setting($urandom(), 31'($urandom_range(1000, 1)),
                         11'($urandom_range(1024, 2)),
                         rand_q824(), rand_q824(), 2'($urandom()), 2'($urandom()),
                         {8'($urandom()), $urandom()});
        default: write_setting(-5000, 100, 64, 0, 32'h0080_0000, 3, 1, 40'h0012_3456);
      endcase
      no_idle = (ph == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(49) == 0) no_idle = ~no_idle;
        send_request(make_request());
      end
    end

    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
